// ===== rtl/tpc_pkg.sv =====
// Shared types, widths, codes and the multiply-accumulate microprogram
// for the three-point touch calibration block. No dependencies.
package tpc_pkg;

	// coordinate width and derived datapath widths
	localparam int COORD_BITS = 12;
	localparam int DIFF_W     = COORD_BITS + 1;        // signed coordinate difference
	localparam int K_W        = 2 * COORD_BITS + 1;    // cofactor x_i*y_j - x_j*y_i
	localparam int GAIN_W     = 2 * COORD_BITS + 3;    // A, B, D, E and divisor
	localparam int OFF_W      = 3 * COORD_BITS + 4;    // C and F
	localparam int PROD_W     = GAIN_W + DIFF_W;       // shared multiplier output
	localparam int ACC_W      = PROD_W + 2;            // accumulator
	localparam int CNT_W      = $clog2(COORD_BITS);    // divider bit counter

	// stream and configuration widths
	localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = 2 + 2 * COORD_BITS;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_T1X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_T1Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_T2X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_T2Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_T3X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_T3Y = 3'd5;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SINGULAR = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MAPPED   = 2'd3;

	// phase values
	localparam logic [1:0] PH_CALIBRATED = 2'd3;
	localparam logic [1:0] PH_THIRD      = 2'd2;

	// wide multiplier operand select
	localparam logic [3:0] A_DX13 = 4'd0;
	localparam logic [3:0] A_DX23 = 4'd1;
	localparam logic [3:0] A_DU13 = 4'd2;
	localparam logic [3:0] A_DU23 = 4'd3;
	localparam logic [3:0] A_DV13 = 4'd4;
	localparam logic [3:0] A_DV23 = 4'd5;
	localparam logic [3:0] A_X1   = 4'd6;
	localparam logic [3:0] A_X2   = 4'd7;
	localparam logic [3:0] A_X3   = 4'd8;
	localparam logic [3:0] A_K1   = 4'd9;
	localparam logic [3:0] A_K2   = 4'd10;
	localparam logic [3:0] A_K3   = 4'd11;
	localparam logic [3:0] A_GA   = 4'd12;
	localparam logic [3:0] A_GB   = 4'd13;
	localparam logic [3:0] A_GD   = 4'd14;
	localparam logic [3:0] A_GE   = 4'd15;

	// narrow multiplier operand select
	localparam logic [3:0] B_DY13 = 4'd0;
	localparam logic [3:0] B_DY23 = 4'd1;
	localparam logic [3:0] B_DU23 = 4'd2;
	localparam logic [3:0] B_DX23 = 4'd3;
	localparam logic [3:0] B_DV23 = 4'd4;
	localparam logic [3:0] B_Y1   = 4'd5;
	localparam logic [3:0] B_Y2   = 4'd6;
	localparam logic [3:0] B_Y3   = 4'd7;
	localparam logic [3:0] B_U1   = 4'd8;
	localparam logic [3:0] B_U2   = 4'd9;
	localparam logic [3:0] B_U3   = 4'd10;
	localparam logic [3:0] B_V1   = 4'd11;
	localparam logic [3:0] B_V2   = 4'd12;
	localparam logic [3:0] B_V3   = 4'd13;
	localparam logic [3:0] B_TX   = 4'd14;
	localparam logic [3:0] B_TY   = 4'd15;

	// accumulator base select
	localparam logic [1:0] BASE_ZERO = 2'd0;
	localparam logic [1:0] BASE_ACC  = 2'd1;
	localparam logic [1:0] BASE_OFFC = 2'd2;
	localparam logic [1:0] BASE_OFFF = 2'd3;

	// accumulator destination
	localparam logic [3:0] D_NONE = 4'd0;
	localparam logic [3:0] D_DIV  = 4'd1;
	localparam logic [3:0] D_GA   = 4'd2;
	localparam logic [3:0] D_GB   = 4'd3;
	localparam logic [3:0] D_GD   = 4'd4;
	localparam logic [3:0] D_GE   = 4'd5;
	localparam logic [3:0] D_K1   = 4'd6;
	localparam logic [3:0] D_K2   = 4'd7;
	localparam logic [3:0] D_K3   = 4'd8;
	localparam logic [3:0] D_OFFC = 4'd9;
	localparam logic [3:0] D_OFFF = 4'd10;
	localparam logic [3:0] D_NUMX = 4'd11;
	localparam logic [3:0] D_NUMY = 4'd12;

	// microprogram layout
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_SOLVE = 5'd0;
	localparam logic [STEP_W-1:0] STEP_MAP   = 5'd22;

	// one multiply-accumulate operation
	typedef struct packed {
		logic [3:0] a_sel;
		logic [3:0] b_sel;
		logic       neg;
		logic [1:0] base;
		logic [3:0] dest;
		logic       last;
	} uop_t;

	function automatic uop_t mk_uop(input logic [3:0] a, input logic [3:0] b,
		input logic n, input logic [1:0] bs, input logic [3:0] d, input logic l);
		uop_t u;
		u.a_sel = a;
		u.b_sel = b;
		u.neg   = n;
		u.base  = bs;
		u.dest  = d;
		u.last  = l;
		return u;
	endfunction

	// Solve: divisor first (checked for zero), then gains, cofactors, offsets.
	// C = u1*k1 + u2*k2 + u3*k3 with k1 = x2y3-x3y2, k2 = x3y1-x1y3, k3 = x1y2-x2y1.
	// Map: num = A*x + B*y + C and D*x + E*y + F.
	function automatic uop_t uop_f(input logic [STEP_W-1:0] step);
		uop_t u;
		case (step)
			5'd0:  u = mk_uop(A_DX13, B_DY23, 1'b0, BASE_ZERO, D_NONE, 1'b0);
			5'd1:  u = mk_uop(A_DX23, B_DY13, 1'b1, BASE_ACC,  D_DIV,  1'b0);
			5'd2:  u = mk_uop(A_DU13, B_DY23, 1'b0, BASE_ZERO, D_NONE, 1'b0);
			5'd3:  u = mk_uop(A_DU23, B_DY13, 1'b1, BASE_ACC,  D_GA,   1'b0);
			5'd4:  u = mk_uop(A_DX13, B_DU23, 1'b0, BASE_ZERO, D_NONE, 1'b0);
			5'd5:  u = mk_uop(A_DU13, B_DX23, 1'b1, BASE_ACC,  D_GB,   1'b0);
			5'd6:  u = mk_uop(A_DV13, B_DY23, 1'b0, BASE_ZERO, D_NONE, 1'b0);
			5'd7:  u = mk_uop(A_DV23, B_DY13, 1'b1, BASE_ACC,  D_GD,   1'b0);
			5'd8:  u = mk_uop(A_DX13, B_DV23, 1'b0, BASE_ZERO, D_NONE, 1'b0);
			5'd9:  u = mk_uop(A_DV13, B_DX23, 1'b1, BASE_ACC,  D_GE,   1'b0);
			5'd10: u = mk_uop(A_X2,   B_Y3,   1'b0, BASE_ZERO, D_NONE, 1'b0);
			5'd11: u = mk_uop(A_X3,   B_Y2,   1'b1, BASE_ACC,  D_K1,   1'b0);
			5'd12: u = mk_uop(A_X3,   B_Y1,   1'b0, BASE_ZERO, D_NONE, 1'b0);
			5'd13: u = mk_uop(A_X1,   B_Y3,   1'b1, BASE_ACC,  D_K2,   1'b0);
			5'd14: u = mk_uop(A_X1,   B_Y2,   1'b0, BASE_ZERO, D_NONE, 1'b0);
			5'd15: u = mk_uop(A_X2,   B_Y1,   1'b1, BASE_ACC,  D_K3,   1'b0);
			5'd16: u = mk_uop(A_K1,   B_U1,   1'b0, BASE_ZERO, D_NONE, 1'b0);
			5'd17: u = mk_uop(A_K2,   B_U2,   1'b0, BASE_ACC,  D_NONE, 1'b0);
			5'd18: u = mk_uop(A_K3,   B_U3,   1'b0, BASE_ACC,  D_OFFC, 1'b0);
			5'd19: u = mk_uop(A_K1,   B_V1,   1'b0, BASE_ZERO, D_NONE, 1'b0);
			5'd20: u = mk_uop(A_K2,   B_V2,   1'b0, BASE_ACC,  D_NONE, 1'b0);
			5'd21: u = mk_uop(A_K3,   B_V3,   1'b0, BASE_ACC,  D_OFFF, 1'b1);
			5'd22: u = mk_uop(A_GA,   B_TX,   1'b0, BASE_OFFC, D_NONE, 1'b0);
			5'd23: u = mk_uop(A_GB,   B_TY,   1'b0, BASE_ACC,  D_NUMX, 1'b0);
			5'd24: u = mk_uop(A_GD,   B_TX,   1'b0, BASE_OFFF, D_NONE, 1'b0);
			5'd25: u = mk_uop(A_GE,   B_TY,   1'b0, BASE_ACC,  D_NUMY, 1'b1);
			default: u = mk_uop(A_DX13, B_DY13, 1'b0, BASE_ZERO, D_NONE, 1'b1);
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/touch_three_point_calibration.sv =====
// Three-point touch calibration: capture, coefficient solve and point mapping.
// One shared multiply-accumulate unit under a microsequencer, one serial divider.
// Depends on tpc_pkg.
//
// Per input transaction: the first two points are only stored; the third runs the
// solve, 22 products through the shared multiplier, cut short after the divisor
// when singular; a mapped point takes 4 products, then a divider run at one
// quotient bit per cycle for each coordinate. One item at a time; input ready
// again the cycle after its result is loaded into the output register.
// Reset (arst_n low, asynchronous): phase 0, coefficients and targets zero,
// output empty. No clearing pass.
module touch_three_point_calibration (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tpc_pkg::IN_DATA_W-1:0]       s_tdata,   // touch_x, touch_y
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tpc_pkg::OUT_DATA_W-1:0]      m_tdata,   // points_taken, mapped_x, mapped_y
	output logic [tpc_pkg::STATUS_W-1:0]        m_tuser,   // status
	// configuration write port
	input  logic                                cfg_en,
	input  logic [tpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tpc_pkg::COORD_BITS-1:0]      cfg_data
);
	import tpc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CALC = 3'd1;
	localparam logic [2:0] S_DSET = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	// control state
	logic [2:0]              state_q;
	logic [1:0]              phase_q;
	logic [STEP_W-1:0]       step_q;
	logic                    iss_done_q;
	logic                    vld_s1;
	uop_t                    ctl_s1;
	logic                    sel_y_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    m_tvalid_q;

	// datapath storage
	logic [COORD_BITS-1:0]   tgt_q [6];
	logic [COORD_BITS-1:0]   cap_q [6];
	logic [COORD_BITS-1:0]   tx_q, ty_q;
	logic signed [GAIN_W-1:0] ga_q, gb_q, gd_q, ge_q, div_q;
	logic signed [OFF_W-1:0]  offc_q, offf_q;
	logic signed [K_W-1:0]    k1_q, k2_q, k3_q;
	logic signed [ACC_W-1:0]  acc_q, numx_q, numy_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [ACC_W-1:0]        rem_q, dsh_q;
	logic [COORD_BITS-1:0]   quo_q;
	logic [COORD_BITS-1:0]   mx_q, my_q;
	logic [STATUS_W-1:0]     res_status_q;
	logic [1:0]              res_taken_q;
	logic [STATUS_W-1:0]     out_status_q;
	logic [1:0]              out_taken_q;
	logic [COORD_BITS-1:0]   out_mx_q, out_my_q;

	// handshake strobes
	logic accept, out_free, issue, singular, calc_end;
	logic [COORD_BITS-1:0] in_x, in_y;
	uop_t uop;

	assign in_x     = s_tdata[COORD_BITS-1:0];
	assign in_y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign issue    = (state_q == S_CALC) && !iss_done_q;
	assign uop      = uop_f(step_q);

	// coordinate differences for the solve
	logic signed [DIFF_W-1:0] dx13, dx23, dy13, dy23, du13, du23, dv13, dv23;
	assign dx13 = $signed({1'b0, cap_q[0]}) - $signed({1'b0, cap_q[4]});
	assign dx23 = $signed({1'b0, cap_q[2]}) - $signed({1'b0, cap_q[4]});
	assign dy13 = $signed({1'b0, cap_q[1]}) - $signed({1'b0, cap_q[5]});
	assign dy23 = $signed({1'b0, cap_q[3]}) - $signed({1'b0, cap_q[5]});
	assign du13 = $signed({1'b0, tgt_q[0]}) - $signed({1'b0, tgt_q[4]});
	assign du23 = $signed({1'b0, tgt_q[2]}) - $signed({1'b0, tgt_q[4]});
	assign dv13 = $signed({1'b0, tgt_q[1]}) - $signed({1'b0, tgt_q[5]});
	assign dv23 = $signed({1'b0, tgt_q[3]}) - $signed({1'b0, tgt_q[5]});

	// shared multiplier operand select
	logic signed [GAIN_W-1:0] opa;
	logic signed [DIFF_W-1:0] opb;

	always_comb begin
		case (uop.a_sel)
			A_DX13:  opa = GAIN_W'(dx13);
			A_DX23:  opa = GAIN_W'(dx23);
			A_DU13:  opa = GAIN_W'(du13);
			A_DU23:  opa = GAIN_W'(du23);
			A_DV13:  opa = GAIN_W'(dv13);
			A_DV23:  opa = GAIN_W'(dv23);
			A_X1:    opa = $signed(GAIN_W'(cap_q[0]));
			A_X2:    opa = $signed(GAIN_W'(cap_q[2]));
			A_X3:    opa = $signed(GAIN_W'(cap_q[4]));
			A_K1:    opa = GAIN_W'(k1_q);
			A_K2:    opa = GAIN_W'(k2_q);
			A_K3:    opa = GAIN_W'(k3_q);
			A_GA:    opa = ga_q;
			A_GB:    opa = gb_q;
			A_GD:    opa = gd_q;
			A_GE:    opa = ge_q;
			default: opa = '0;
		endcase
	end

	always_comb begin
		case (uop.b_sel)
			B_DY13:  opb = dy13;
			B_DY23:  opb = dy23;
			B_DU23:  opb = du23;
			B_DX23:  opb = dx23;
			B_DV23:  opb = dv23;
			B_Y1:    opb = $signed({1'b0, cap_q[1]});
			B_Y2:    opb = $signed({1'b0, cap_q[3]});
			B_Y3:    opb = $signed({1'b0, cap_q[5]});
			B_U1:    opb = $signed({1'b0, tgt_q[0]});
			B_U2:    opb = $signed({1'b0, tgt_q[2]});
			B_U3:    opb = $signed({1'b0, tgt_q[4]});
			B_V1:    opb = $signed({1'b0, tgt_q[1]});
			B_V2:    opb = $signed({1'b0, tgt_q[3]});
			B_V3:    opb = $signed({1'b0, tgt_q[5]});
			B_TX:    opb = $signed({1'b0, tx_q});
			B_TY:    opb = $signed({1'b0, ty_q});
			default: opb = '0;
		endcase
	end

	// accumulate stage
	logic signed [ACC_W-1:0] base_v, acc_next;

	always_comb begin
		case (ctl_s1.base)
			BASE_ZERO: base_v = '0;
			BASE_ACC:  base_v = acc_q;
			BASE_OFFC: base_v = ACC_W'(offc_q);
			BASE_OFFF: base_v = ACC_W'(offf_q);
			default:   base_v = '0;
		endcase
		acc_next = ctl_s1.neg ? base_v - ACC_W'(prod_s1) : base_v + ACC_W'(prod_s1);
	end

	assign singular = vld_s1 && (ctl_s1.dest == D_DIV) && (acc_next == '0);
	assign calc_end = vld_s1 && ctl_s1.last;

	// divider setup: sign test, magnitudes, saturation test
	logic signed [ACC_W-1:0] num_sel;
	logic [ACC_W-1:0]        nm, dm_ext;
	logic [GAIN_W-1:0]       dm;
	logic                    num_neg, div_neg, q_zero, q_sat;

	always_comb begin
		num_sel = sel_y_q ? numy_q : numx_q;
		num_neg = num_sel[ACC_W-1];
		div_neg = div_q[GAIN_W-1];
		nm      = num_neg ? ACC_W'(-num_sel) : ACC_W'(num_sel);
		dm      = div_neg ? GAIN_W'(-div_q) : GAIN_W'(div_q);
		dm_ext  = ACC_W'(dm);
		q_zero  = (div_q == '0) || (num_sel == '0) || (num_neg != div_neg);
		q_sat   = (nm >= (dm_ext << COORD_BITS));
	end

	// restoring divider step
	logic                  ge_bit;
	logic [ACC_W-1:0]      rem_next;
	logic [COORD_BITS-1:0] quo_next;
	logic                  div_last;

	assign ge_bit   = (rem_q >= dsh_q);
	assign rem_next = ge_bit ? rem_q - dsh_q : rem_q;
	assign quo_next = {quo_q[COORD_BITS-2:0], ge_bit};
	assign div_last = (cnt_q == CNT_W'(COORD_BITS - 1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= '0;
			step_q     <= STEP_SOLVE;
			iss_done_q <= 1'b0;
			vld_s1     <= 1'b0;
			sel_y_q    <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// output valid: set when a result is loaded, cleared when taken
			if ((state_q == S_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			vld_s1 <= issue && !singular;
			if (issue) begin
				step_q <= step_q + STEP_W'(1);
				if (uop.last) begin
					iss_done_q <= 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						iss_done_q <= 1'b0;
						if (phase_q == PH_CALIBRATED) begin
							step_q  <= STEP_MAP;
							state_q <= S_CALC;
						end else if (phase_q == PH_THIRD) begin
							step_q  <= STEP_SOLVE;
							state_q <= S_CALC;
						end else begin
							phase_q <= phase_q + 2'd1;
							state_q <= S_FIN;
						end
					end
				end
				S_CALC: begin
					if (singular) begin
						phase_q <= '0;
						state_q <= S_FIN;
					end else if (calc_end) begin
						if (phase_q == PH_CALIBRATED) begin
							sel_y_q <= 1'b0;
							state_q <= S_DSET;
						end else begin
							phase_q <= PH_CALIBRATED;
							state_q <= S_FIN;
						end
					end
				end
				S_DSET: begin
					cnt_q <= '0;
					if (q_zero || q_sat) begin
						sel_y_q <= 1'b1;
						state_q <= sel_y_q ? S_FIN : S_DSET;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (div_last) begin
						sel_y_q <= 1'b1;
						state_q <= sel_y_q ? S_FIN : S_DSET;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// target registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				tgt_q[i] <= '0;
			end
		end else if (cfg_en && (cfg_index <= REG_T3Y)) begin
			tgt_q[cfg_index] <= cfg_data;
		end
	end

	// calibration coefficients, committed only for a nonsingular solve
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ga_q   <= '0;
			gb_q   <= '0;
			gd_q   <= '0;
			ge_q   <= '0;
			div_q  <= '0;
			offc_q <= '0;
			offf_q <= '0;
		end else if (vld_s1) begin
			case (ctl_s1.dest)
				D_DIV:   if (acc_next != '0) div_q <= acc_next[GAIN_W-1:0];
				D_GA:    ga_q   <= acc_next[GAIN_W-1:0];
				D_GB:    gb_q   <= acc_next[GAIN_W-1:0];
				D_GD:    gd_q   <= acc_next[GAIN_W-1:0];
				D_GE:    ge_q   <= acc_next[GAIN_W-1:0];
				D_OFFC:  offc_q <= acc_next[OFF_W-1:0];
				D_OFFF:  offf_q <= acc_next[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// multiplier, accumulator and scratch registers
	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= opa * opb;
			ctl_s1  <= uop;
		end
		if (vld_s1) begin
			acc_q <= acc_next;
			case (ctl_s1.dest)
				D_K1:    k1_q   <= acc_next[K_W-1:0];
				D_K2:    k2_q   <= acc_next[K_W-1:0];
				D_K3:    k3_q   <= acc_next[K_W-1:0];
				D_NUMX:  numx_q <= acc_next;
				D_NUMY:  numy_q <= acc_next;
				default: ;
			endcase
		end
	end

	// sample capture, result fields and divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					tx_q <= in_x;
					ty_q <= in_y;
					mx_q <= '0;
					my_q <= '0;
					if (phase_q != PH_CALIBRATED) begin
						cap_q[{phase_q, 1'b0}] <= in_x;
						cap_q[{phase_q, 1'b1}] <= in_y;
					end
					if (phase_q == PH_CALIBRATED) begin
						res_status_q <= ST_MAPPED;
						res_taken_q  <= PH_CALIBRATED;
					end else begin
						res_status_q <= ST_STORED;
						res_taken_q  <= phase_q + 2'd1;
					end
				end
			end
			S_CALC: begin
				if (singular) begin
					res_status_q <= ST_SINGULAR;
					res_taken_q  <= '0;
				end else if (calc_end && (phase_q != PH_CALIBRATED)) begin
					res_status_q <= ST_DONE;
					res_taken_q  <= PH_CALIBRATED;
				end
			end
			S_DSET: begin
				rem_q <= nm;
				dsh_q <= dm_ext << (COORD_BITS - 1);
				quo_q <= '0;
				if (q_zero || q_sat) begin
					if (sel_y_q) begin
						my_q <= q_zero ? '0 : '1;
					end else begin
						mx_q <= q_zero ? '0 : '1;
					end
				end
			end
			S_DIV: begin
				rem_q <= rem_next;
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_next;
				if (div_last) begin
					if (sel_y_q) begin
						my_q <= quo_next;
					end else begin
						mx_q <= quo_next;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_taken_q  <= res_taken_q;
					out_mx_q     <= mx_q;
					out_my_q     <= my_q;
				end
			end
			default: ;
		endcase
	end

	// output register
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_my_q, out_mx_q, out_taken_q};

`ifndef SYNTH
	// one item at a time: ready drops right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in progress");

	// mapping only ever runs with a nonzero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CALIBRATED) |-> (div_q != '0))
		else $error("calibrated with zero divisor");

	// divider remainder stays below twice the shifted divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> ({1'b0, rem_q} < ({1'b0, dsh_q} << 1)))
		else $error("divider remainder out of range");

	// a mapped result always reports three points taken
	a_mapped_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_MAPPED)) |-> (m_tdata[1:0] == PH_CALIBRATED))
		else $error("mapped result with wrong point count");

	// non-mapped results carry zero coordinates
	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_MAPPED)) |->
		(m_tdata[OUT_BITS-1:2] == '0))
		else $error("coordinates set on a calibration result");
`endif

endmodule

// ===== test/touch_three_point_calibration_test.sv =====
// Self-checking testbench for touch_three_point_calibration: directed table, then
// random touches under four handshake idling mixes, checked by an in-bench predictor.
// Depends on tpc_pkg and the touch_three_point_calibration RTL.
module touch_three_point_calibration_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tpc_pkg::*;

	// register indexes past the last target; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;
	localparam logic [COORD_BITS-1:0] C_MAX = '1;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_PER_PHASE = 270;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [1:0]            taken;
		logic [COORD_BITS-1:0] mx;
		logic [COORD_BITS-1:0] my;
	} touch_result_t;

	typedef enum logic {ROW_TOUCH, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;     // register index for writes
		logic [COORD_BITS-1:0] a;       // touch x, or write data
		logic [COORD_BITS-1:0] b;       // touch y
		logic                  typed;   // expectation given in the row
		touch_result_t         want;
	} stim_row_t;

	localparam touch_result_t NONE = '0;

	// directed stimulus; rows without a typed result go through the predictor
	stim_row_t directed_rows [29] = '{
		// targets still zero: two stored points, then a repeated point is singular
		'{ROW_TOUCH, REG_T1X, 12'd0,    12'd0,    1'b1, '{ST_STORED,   2'd1, 12'd0, 12'd0}},
		'{ROW_TOUCH, REG_T1X, 12'd4095, 12'd4095, 1'b1, '{ST_STORED,   2'd2, 12'd0, 12'd0}},
		'{ROW_TOUCH, REG_T1X, 12'd4095, 12'd4095, 1'b1, '{ST_SINGULAR, 2'd0, 12'd0, 12'd0}},
		// targets at the display corners, spare indexes written too
		'{ROW_WRITE, REG_T1X,    12'd0,    12'd0, 1'b0, NONE},
		'{ROW_WRITE, REG_T1Y,    12'd0,    12'd0, 1'b0, NONE},
		'{ROW_WRITE, REG_T2X,    12'd0,    12'd0, 1'b0, NONE},
		'{ROW_WRITE, REG_T2Y,    12'd4095, 12'd0, 1'b0, NONE},
		'{ROW_WRITE, REG_T3X,    12'd4095, 12'd0, 1'b0, NONE},
		'{ROW_WRITE, REG_T3Y,    12'd0,    12'd0, 1'b0, NONE},
		'{ROW_WRITE, REG_SPARE6, 12'd4095, 12'd0, 1'b0, NONE},
		'{ROW_WRITE, REG_SPARE7, 12'd4095, 12'd0, 1'b0, NONE},
		// three distinct but collinear points: singular again
		'{ROW_TOUCH, REG_T1X, 12'd4095, 12'd0,    1'b1, '{ST_STORED,   2'd1, 12'd0, 12'd0}},
		'{ROW_TOUCH, REG_T1X, 12'd0,    12'd4095, 1'b1, '{ST_STORED,   2'd2, 12'd0, 12'd0}},
		'{ROW_TOUCH, REG_T1X, 12'd2048, 12'd2047, 1'b1, '{ST_SINGULAR, 2'd0, 12'd0, 12'd0}},
		// good triangle, negative divisor
		'{ROW_TOUCH, REG_T1X, 12'd1000, 12'd1000, 1'b1, '{ST_STORED,   2'd1, 12'd0, 12'd0}},
		'{ROW_TOUCH, REG_T1X, 12'd1000, 12'd2000, 1'b1, '{ST_STORED,   2'd2, 12'd0, 12'd0}},
		'{ROW_TOUCH, REG_T1X, 12'd2000, 12'd1000, 1'b1, '{ST_DONE,     2'd3, 12'd0, 12'd0}},
		// panel corners saturate low and high
		'{ROW_TOUCH, REG_T1X, 12'd0,    12'd0,    1'b1, '{ST_MAPPED, 2'd3, 12'd0,    12'd0}},
		'{ROW_TOUCH, REG_T1X, 12'd4095, 12'd4095, 1'b1, '{ST_MAPPED, 2'd3, 12'd4095, 12'd4095}},
		'{ROW_TOUCH, REG_T1X, 12'd0,    12'd4095, 1'b1, '{ST_MAPPED, 2'd3, 12'd0,    12'd4095}},
		'{ROW_TOUCH, REG_T1X, 12'd4095, 12'd0,    1'b1, '{ST_MAPPED, 2'd3, 12'd4095, 12'd0}},
		// calibration points land exactly on their targets; an interior point goes through the predictor
		'{ROW_TOUCH, REG_T1X, 12'd2000, 12'd1000, 1'b1, '{ST_MAPPED, 2'd3, 12'd4095, 12'd0}},
		'{ROW_TOUCH, REG_T1X, 12'd1000, 12'd2000, 1'b1, '{ST_MAPPED, 2'd3, 12'd0,    12'd4095}},
		'{ROW_TOUCH, REG_T1X, 12'd1500, 12'd1700, 1'b0, NONE},
		// target changes after calibration must not move the mapping
		'{ROW_WRITE, REG_T1X, 12'd4095, 12'd0, 1'b0, NONE},
		'{ROW_WRITE, REG_T2Y, 12'd0,    12'd0, 1'b0, NONE},
		'{ROW_WRITE, REG_T3X, 12'd0,    12'd0, 1'b0, NONE},
		'{ROW_TOUCH, REG_T1X, 12'd1500, 12'd1700, 1'b0, NONE},
		'{ROW_TOUCH, REG_T1X, 12'd1234, 12'd3210, 1'b0, NONE}
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_W-1:0]     s_tdata;    // touch_x, touch_y
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]    m_tdata;    // points_taken, mapped_x, mapped_y
	logic [STATUS_W-1:0]      m_tuser;    // status
	logic                     cfg_en;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [COORD_BITS-1:0]    cfg_data;

	// handshake pressure knobs
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_req = 1'b0;
	logic        hold_off = 1'b0;

	// predictor state
	logic [1:0]            cal_phase = '0;
	logic [COORD_BITS-1:0] target_regs [6] = '{default: '0};
	longint                touch_pts [6];
	longint                gain_abde [4] = '{default: 0};
	longint                off_cf [2] = '{default: 0};
	longint                cal_div = 0;

	touch_result_t expected_results [$];
	int unsigned   mismatches = 0;

	touch_three_point_calibration i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [COORD_BITS-1:0] clamp_coord(input longint v);
		if (v < 0) return '0;
		if (v > longint'(C_MAX)) return C_MAX;
		return v[COORD_BITS-1:0];
	endfunction

	// affine map of one axis, signed division truncating toward zero
	function automatic logic [COORD_BITS-1:0] map_axis(input longint ga, input longint gb,
		input longint off, input longint x, input longint y);
		longint num;
		num = ga * x + gb * y + off;
		if (cal_div == 0) return '0;
		return clamp_coord(num / cal_div);
	endfunction

	// expected result of one touch; advances the capture state
	function automatic touch_result_t predict_touch(input logic [COORD_BITS-1:0] tx,
		input logic [COORD_BITS-1:0] ty);
		touch_result_t r;
		longint x, y, x1, y1, x2, y2, x3, y3, u1, v1, u2, v2, u3, v3, dv;
		r = '0;
		x = longint'(tx);
		y = longint'(ty);
		if (cal_phase != PH_CALIBRATED) begin
			touch_pts[2 * cal_phase]     = x;
			touch_pts[2 * cal_phase + 1] = y;
			if (cal_phase != PH_THIRD) begin
				cal_phase = cal_phase + 2'd1;
				r.status  = ST_STORED;
			end else begin
				x1 = touch_pts[0]; y1 = touch_pts[1];
				x2 = touch_pts[2]; y2 = touch_pts[3];
				x3 = touch_pts[4]; y3 = touch_pts[5];
				u1 = longint'(target_regs[0]); v1 = longint'(target_regs[1]);
				u2 = longint'(target_regs[2]); v2 = longint'(target_regs[3]);
				u3 = longint'(target_regs[4]); v3 = longint'(target_regs[5]);
				dv = (x1 - x3) * (y2 - y3) - (x2 - x3) * (y1 - y3);
				if (dv == 0) begin
					// singular: restart capture, keep the coefficients
					cal_phase = '0;
					r.status  = ST_SINGULAR;
				end else begin
					cal_div      = dv;
					gain_abde[0] = (u1 - u3) * (y2 - y3) - (u2 - u3) * (y1 - y3);
					gain_abde[1] = (x1 - x3) * (u2 - u3) - (u1 - u3) * (x2 - x3);
					off_cf[0]    = (x3 * u2 - x2 * u3) * y1 + (x1 * u3 - x3 * u1) * y2
						+ (x2 * u1 - x1 * u2) * y3;
					gain_abde[2] = (v1 - v3) * (y2 - y3) - (v2 - v3) * (y1 - y3);
					gain_abde[3] = (x1 - x3) * (v2 - v3) - (v1 - v3) * (x2 - x3);
					off_cf[1]    = (x3 * v2 - x2 * v3) * y1 + (x1 * v3 - x3 * v1) * y2
						+ (x2 * v1 - x1 * v2) * y3;
					cal_phase = PH_CALIBRATED;
					r.status  = ST_DONE;
				end
			end
			r.taken = cal_phase;
		end else begin
			r.mx     = map_axis(gain_abde[0], gain_abde[1], off_cf[0], x, y);
			r.my     = map_axis(gain_abde[2], gain_abde[3], off_cf[1], x, y);
			r.status = ST_MAPPED;
			r.taken  = 2'd3;
		end
		return r;
	endfunction

	// offer one touch from a falling edge; returns at the falling edge after acceptance
	task automatic push_touch(input logic [COORD_BITS-1:0] tx, input logic [COORD_BITS-1:0] ty,
		input logic typed, input touch_result_t want);
		touch_result_t r;
		cfg_en = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {ty, tx};
		do @(posedge clk); while (!s_tready);
		r = predict_touch(tx, ty);
		expected_results.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		s_tvalid = 1'b0;
		cfg_en   = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
	endtask

	// register write from a falling edge; the caller lowers cfg_en after a batch
	task automatic write_target(input logic [CFG_IDX_W-1:0] idx,
		input logic [COORD_BITS-1:0] val);
		cfg_en    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		if (idx <= REG_T3Y) target_regs[idx] = val;
	endtask

	// receiver: random stall, plus the long hold-off
	always @(negedge clk) begin
		m_tready = !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// long receiver hold-off, counted here so the sender keeps pushing
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// result checker
	always @(posedge clk) begin
		touch_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser;
			got.taken  = m_tdata[1:0];
			got.mx     = m_tdata[2 +: COORD_BITS];
			got.my     = m_tdata[2 + COORD_BITS +: COORD_BITS];
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result status %0d taken %0d x %0d y %0d",
					$time, got.status, got.taken, got.mx, got.my);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: expected status %0d taken %0d x %0d y %0d, got %0d %0d %0d %0d",
						$time, want.status, want.taken, want.mx, want.my,
						got.status, got.taken, got.mx, got.my);
				end
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// stimulus
	initial begin
		int unsigned send_mix [4] = '{0, 84, 0, 8};
		int unsigned stall_mix [4] = '{0, 0, 84, 8};
		logic [COORD_BITS-1:0] val;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_en    = 1'b0;
		cfg_index = REG_T1X;
		cfg_data  = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				if (s_tvalid) drain();
				write_target(directed_rows[i].idx, directed_rows[i].a);
			end else begin
				push_touch(directed_rows[i].a, directed_rows[i].b,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end
		drain();

		// random touches, one idling mix per phase
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = send_mix[p];
			recv_stall_pct = stall_mix[p];
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (p == 0 && n == 20) hold_req = 1'b1;
				push_touch(COORD_BITS'($urandom_range(int'(C_MAX))),
					COORD_BITS'($urandom_range(int'(C_MAX))), 1'b0, NONE);
			end
			drain();
			// rewrite every index while idle; mapping must not change
			for (int r = int'(REG_T1X); r <= int'(REG_SPARE7); r++) begin
				case ($urandom_range(2))
					0: val = '0;
					1: val = C_MAX;
					default: val = COORD_BITS'($urandom_range(int'(C_MAX)));
				endcase
				write_target(r[CFG_IDX_W-1:0], val);
			end
			cfg_en = 1'b0;
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
